// ----- rtl/assert_macros.svh -----
// Assertion helper macros used by sorted_priority_queue.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked property evaluated during reset as well.
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// Sorted priority queue package: sizes, opcodes, status codes, entry and cell control types.
// No dependencies.
package spq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpDelete = 2'd1;
  localparam logic [1:0] OpDump   = 2'd2;

  localparam logic [2:0] StInserted  = 3'd0;
  localparam logic [2:0] StFull      = 3'd1;
  localparam logic [2:0] StDeleted   = 3'd2;
  localparam logic [2:0] StUnderflow = 3'd3;
  localparam logic [2:0] StDump      = 3'd4;
  localparam logic [2:0] StEmpty     = 3'd5;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    CmdHold,
    CmdInsert,
    CmdShiftLeft,
    CmdRotate
  } cell_cmd_e;

  // Per-cell control derived from the fill count.
  typedef struct packed {
    logic occupied;
    logic tail;
  } cell_ctrl_t;

endpackage

// ----- rtl/spq_in_if.sv -----
// Input channel of the sorted priority queue: valid/ready plus request payload.
// No dependencies.
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] value_in;
  logic signed [15:0] priority_in;

  modport source (output valid, opcode, value_in, priority_in, input ready);
  modport sink   (input valid, opcode, value_in, priority_in, output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
// Output channel of the sorted priority queue: valid/ready plus result payload.
// No dependencies.
interface spq_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] value_out;
  logic signed [15:0] priority_out;
  logic               last;

  modport source (output valid, status, value_out, priority_out, last, input ready);
  modport sink   (input valid, status, value_out, priority_out, last, output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// One storage cell of the queue chain: holds an entry, inserts, shifts, rotates.
// Depends on spq_pkg.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_cmd_e cmd_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_i,
  input  logic               left_keep_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  input  spq_pkg::entry_t    wrap_i,
  output logic               keep_o,
  output spq_pkg::entry_t    entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // Stays in place on insert: occupied and not behind the new entry.
  assign keep_o = ctrl_i.occupied && ($signed(entry_q.prio) <= $signed(new_i.prio));

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i)
      CmdInsert: begin
        if (!keep_o) begin
          entry_d = left_keep_i ? new_i : left_i;
        end
      end
      CmdShiftLeft: entry_d = right_i;
      CmdRotate:    entry_d = ctrl_i.tail ? wrap_i : right_i;
      default:      entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue top level: chain of spq_cell plus fill count and output register.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_cell, assert_macros.svh.
//
// Usage:
//   in_i carries one request per transaction: insert (value, priority),
//   delete front, or dump. out_o returns result transactions; last marks
//   the final result of a request. Smaller priority leaves first, ties in
//   arrival order. Capacity is Depth entries.
//   Insert and delete update the cell chain on acceptance; the result sits
//   in the output register in the cycle after acceptance, and a new request
//   is taken every cycle while results are drained.
//   Dump latches the count, then the chain rotates by one cell per cycle
//   while the output is free, streaming the front cell, and is back in order
//   after count steps; the first entry is registered once dump_q is set.
//   No request is taken while a dump is streaming.
//   Empty dump, underflow and full-insert give one status result each.
//   Opcode 3 is taken and produces nothing.
//   When out_o.ready is low with a valid result, the output register holds and in_i.ready drops.
//   Reset empties the queue (count to zero) and clears the output valid.
`include "assert_macros.svh"
module sorted_priority_queue (
  input  logic clk_i,
  input  logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            dump_q, dump_d;
  logic            out_valid_q, out_valid_d;
  logic [2:0]      status_q, status_d;
  entry_t          res_q, res_d;
  logic            last_q, last_d;

  cell_cmd_e   cmd;
  entry_t      new_entry;
  entry_t      cell_entry [Depth];
  logic        cell_keep  [Depth];
  cell_ctrl_t  cell_ctrl  [Depth];

  logic out_free, acc, is_full, is_empty;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = !dump_q && out_free;
  assign acc       = in_i.valid && in_i.ready;
  assign is_full   = (count_q == CntW'(Depth));
  assign is_empty  = (count_q == '0);

  assign new_entry.prio  = in_i.priority_in;
  assign new_entry.value = in_i.value_in;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign cell_ctrl[i].occupied = (CntW'(i) < count_q);
    assign cell_ctrl[i].tail     = (CntW'(i + 1) == count_q);

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk_i       (clk_i),
        .cmd_i       (cmd),
        .ctrl_i      (cell_ctrl[i]),
        .new_i       (new_entry),
        .left_keep_i (1'b1),
        .left_i      (new_entry),
        .right_i     (cell_entry[i + 1]),
        .wrap_i      (cell_entry[0]),
        .keep_o      (cell_keep[i]),
        .entry_o     (cell_entry[i])
      );
    end else if (i == Depth - 1) begin : g_end
      spq_cell u_cell (
        .clk_i       (clk_i),
        .cmd_i       (cmd),
        .ctrl_i      (cell_ctrl[i]),
        .new_i       (new_entry),
        .left_keep_i (cell_keep[i - 1]),
        .left_i      (cell_entry[i - 1]),
        .right_i     (cell_entry[0]),
        .wrap_i      (cell_entry[0]),
        .keep_o      (cell_keep[i]),
        .entry_o     (cell_entry[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk_i       (clk_i),
        .cmd_i       (cmd),
        .ctrl_i      (cell_ctrl[i]),
        .new_i       (new_entry),
        .left_keep_i (cell_keep[i - 1]),
        .left_i      (cell_entry[i - 1]),
        .right_i     (cell_entry[i + 1]),
        .wrap_i      (cell_entry[0]),
        .keep_o      (cell_keep[i]),
        .entry_o     (cell_entry[i])
      );
    end
  end

  always_comb begin
    cmd         = CmdHold;
    count_d     = count_q;
    rem_d       = rem_q;
    dump_d      = dump_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    res_d       = res_q;
    last_d      = last_q;

    if (out_free) begin
      out_valid_d = 1'b0;
    end

    if (acc) begin
      unique case (in_i.opcode)
        OpInsert: begin
          out_valid_d = 1'b1;
          res_d       = '0;
          last_d      = 1'b1;
          if (is_full) begin
            status_d = StFull;
          end else begin
            status_d = StInserted;
            cmd      = CmdInsert;
            count_d  = count_q + CntW'(1);
          end
        end
        OpDelete: begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          if (is_empty) begin
            status_d = StUnderflow;
            res_d    = '0;
          end else begin
            status_d = StDeleted;
            res_d    = cell_entry[0];
            cmd      = CmdShiftLeft;
            count_d  = count_q - CntW'(1);
          end
        end
        OpDump: begin
          if (is_empty) begin
            out_valid_d = 1'b1;
            status_d    = StEmpty;
            res_d       = '0;
            last_d      = 1'b1;
          end else begin
            dump_d = 1'b1;
            rem_d  = count_q;
          end
        end
        default: ;
      endcase
    end else if (dump_q && out_free) begin
      cmd         = CmdRotate;
      out_valid_d = 1'b1;
      status_d    = StDump;
      res_d       = cell_entry[0];
      last_d      = (rem_q == CntW'(1));
      rem_d       = rem_q - CntW'(1);
      if (rem_q == CntW'(1)) begin
        dump_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rem_q       <= '0;
      dump_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rem_q       <= rem_d;
      dump_q      <= dump_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_q    <= res_d;
    last_q   <= last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.value_out    = res_q.value;
  assign out_o.priority_out = res_q.prio;
  assign out_o.last         = last_q;

  `SPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth), "count above depth")
  `SPQ_ASSERT(a_dump_rem, clk_i, rst_ni, dump_q |-> (rem_q != '0 && rem_q <= count_q),
    "dump remainder out of range")
  `SPQ_ASSERT(a_full_reject, clk_i, rst_ni,
    (acc && in_i.opcode == OpInsert && is_full) |=> (out_valid_q && status_q == StFull
      && $stable(count_q)), "full insert not rejected")
  `SPQ_ASSERT(a_dump_end, clk_i, rst_ni,
    (dump_q && out_free && rem_q == CntW'(1)) |=> (!dump_q && out_valid_q && last_q),
    "dump did not end with last")

endmodule
